// File: hdl/ghi_pkg.sv
// Shared types, register codes and microcode word layout for the gyro heading integrator.
`default_nettype none

package ghi_pkg;

	localparam int AVG_COUNT_DEF = 10;
	localparam int STEP_W        = 4;

	localparam logic [15:0] DEADBAND_RESET  = 16'd49;
	localparam logic [15:0] RATE_GAIN_RESET = 16'd19084;
	localparam logic [31:0] TICK_GAIN_RESET = 32'd4295;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [1:0] {
		CFG_DEADBAND  = 2'd0,
		CFG_RATE_GAIN = 2'd1,
		CFG_TICK_GAIN = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic        cmd;
		logic [11:0] sample;
		logic [15:0] elapsed_ticks;
	} item_t;

	typedef struct packed {
		logic signed [31:0] heading;
		logic signed [23:0] rate;
	} result_t;

	typedef struct packed {
		logic [15:0] deadband_sum;
		logic [15:0] rate_gain;
		logic [31:0] tick_gain;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_NOP,
		OP_DIFF,
		OP_RATE,
		OP_RSUM,
		OP_LOAD_A,
		OP_QUOT,
		OP_HEAD
	} op_t;

	typedef enum logic [1:0] {
		MA_MAG,
		MA_TIME,
		MA_RMAG
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_RGAIN,
		MB_TGAIN,
		MB_SECS_HI,
		MB_SECS_LO
	} mul_b_t;

	typedef enum logic [1:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t    op;
		logic   mul_en;
		mul_a_t mul_a;
		mul_b_t mul_b;
	} dp_ctrl_t;

	typedef struct packed {
		dp_ctrl_t dp;
		cond_t    cond;
		step_t    target;
	} ucode_t;

	typedef struct packed {
		logic start;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

// File: hdl/ghi_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module ghi_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  ghi_pkg::dp_status_t status,
	output ghi_pkg::dp_ctrl_t   ctrl
);
	import ghi_pkg::*;

	localparam step_t STEP_IDLE = step_t'(0);
	localparam step_t STEP_QUOT = step_t'(7);

	function automatic ucode_t ucode(input step_t s);
		ucode_t w;
		w = '{dp: '{op: OP_IDLE, mul_en: 1'b0, mul_a: MA_MAG, mul_b: MB_RGAIN},
			cond: COND_NO_START, target: STEP_IDLE};
		unique case (s)
			step_t'(0): ;
			step_t'(1): begin
				w.dp.op = OP_DIFF;
				w.cond  = COND_NEVER;
			end
			step_t'(2): begin
				w.dp = '{op: OP_NOP, mul_en: 1'b1, mul_a: MA_MAG, mul_b: MB_RGAIN};
				w.cond = COND_NEVER;
			end
			step_t'(3): begin
				w.dp = '{op: OP_RATE, mul_en: 1'b1, mul_a: MA_TIME, mul_b: MB_TGAIN};
				w.cond = COND_NEVER;
			end
			step_t'(4): begin
				w.dp.op = OP_RSUM;
				w.cond  = COND_NEVER;
			end
			step_t'(5): begin
				w.dp = '{op: OP_NOP, mul_en: 1'b1, mul_a: MA_RMAG, mul_b: MB_SECS_HI};
				w.cond = COND_NEVER;
			end
			step_t'(6): begin
				w.dp = '{op: OP_LOAD_A, mul_en: 1'b1, mul_a: MA_RMAG, mul_b: MB_SECS_LO};
				w.cond = COND_NEVER;
			end
			step_t'(7): begin
				// Hold here until the output register can take the result.
				w.dp.op = OP_QUOT;
				w.cond  = COND_OUT_BUSY;
				w.target = STEP_QUOT;
			end
			step_t'(8): begin
				w.dp.op = OP_HEAD;
				w.cond  = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: ;
		endcase
		return w;
	endfunction

	step_t  pc_q;
	ucode_t word;
	logic   take_jump;

	assign word = ucode(pc_q);
	assign ctrl = word.dp;

	always_comb begin
		unique case (word.cond)
			COND_NEVER:    take_jump = 1'b0;
			COND_ALWAYS:   take_jump = 1'b1;
			COND_NO_START: take_jump = !status.start;
			COND_OUT_BUSY: take_jump = status.out_busy;
			default:       take_jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (take_jump) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + step_t'(1);
		end
	end

endmodule

`default_nettype wire

// File: hdl/ghi_datapath.sv
// Datapath: group accumulation, shared 32x32 multiplier, rate and heading arithmetic.
`default_nettype none

module ghi_datapath #(
	parameter int AVG_COUNT = ghi_pkg::AVG_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ghi_pkg::dp_ctrl_t   ctrl,
	input  ghi_pkg::cfg_t       cfg,
	input  logic                item_valid,
	input  ghi_pkg::item_t      item,
	output ghi_pkg::result_t    result,
	output logic                result_valid,
	input  logic                result_stall,
	output ghi_pkg::dp_status_t status
);
	import ghi_pkg::*;

	localparam int CNT_W = $clog2(AVG_COUNT + 1);

	// Architectural state.
	logic [CNT_W-1:0]   cnt_q;
	logic               kind_q;
	logic [15:0]        sum_q;
	logic [15:0]        bias_q;
	logic signed [23:0] prev_q;
	logic signed [31:0] heading_q;
	logic [31:0]        time_q;
	logic               out_valid_q;
	result_t            result_q;

	// Working registers of the microprogram.
	logic [63:0]        prod_q;
	logic [16:0]        mag_q;
	logic               neg_q;
	logic               zero_q;
	logic signed [23:0] rate_q;
	logic [24:0]        rmag_q;
	logic               rneg_q;
	logic [63:0]        secs_q;
	logic [56:0]        a_q;
	logic [40:0]        q_q;

	logic               item_fire;
	logic [32:0]        time_sum;
	logic [31:0]        time_nx;
	logic               restart;
	logic [15:0]        sum_nx;
	logic [CNT_W-1:0]   cnt_inc;
	logic               group_done;

	assign item_fire = item_valid && (ctrl.op == OP_IDLE);
	assign time_sum  = {1'b0, time_q} + {17'd0, item.elapsed_ticks};
	assign time_nx   = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
	assign restart   = (cnt_q == '0) || (item.cmd != kind_q);
	assign sum_nx    = (restart ? 16'd0 : sum_q) + {4'd0, item.sample};
	assign cnt_inc   = (restart ? '0 : cnt_q) + CNT_W'(1);
	assign group_done = (cnt_inc == CNT_W'(AVG_COUNT));

	assign status = '{start: item_fire && group_done && item.cmd,
		out_busy: out_valid_q && result_stall};

	// Multiplier operands.
	logic [31:0] mul_a;
	logic [31:0] mul_b;

	always_comb begin
		unique case (ctrl.mul_a)
			MA_MAG:  mul_a = {15'd0, mag_q};
			MA_TIME: mul_a = time_q;
			MA_RMAG: mul_a = {7'd0, rmag_q};
			default: mul_a = 32'd0;
		endcase
		unique case (ctrl.mul_b)
			MB_RGAIN:   mul_b = {16'd0, cfg.rate_gain};
			MB_TGAIN:   mul_b = cfg.tick_gain;
			MB_SECS_HI: mul_b = secs_q[63:32];
			MB_SECS_LO: mul_b = secs_q[31:0];
			default:    mul_b = 32'd0;
		endcase
	end

	// Difference against the bias.
	logic [16:0] diff;
	logic [16:0] diff_mag;

	assign diff     = {1'b0, sum_q} - {1'b0, bias_q};
	assign diff_mag = diff[16] ? (17'd0 - diff) : diff;

	// Rate from the scaled magnitude.
	logic [23:0] rate_abs;
	logic [23:0] rate_nx;

	assign rate_abs = {3'd0, prod_q[32:12]};
	assign rate_nx  = zero_q ? 24'd0 : (neg_q ? (24'd0 - rate_abs) : rate_abs);

	// Sum of previous and new rate.
	logic [24:0] rsum;

	assign rsum = {prev_q[23], prev_q} + {rate_q[23], rate_q};

	// Quotient of the 89-bit product by 2^33, built from the two partial products.
	logic [57:0] lo_sum;
	logic [56:0] q_full;
	logic [40:0] q_sat;

	assign lo_sum = {25'd0, a_q[0], 32'd0} + {1'b0, prod_q[56:0]};
	assign q_full = {1'b0, a_q[56:1]} + {32'd0, lo_sum[57:33]};
	assign q_sat  = (q_full > {16'd0, 41'h100_0000_0000}) ? 41'h100_0000_0000 : q_full[40:0];

	// Heading update with saturation to the signed 32-bit range.
	logic [42:0] head_ext;
	logic [42:0] q_ext;
	logic [42:0] head_sum;
	logic [31:0] head_nx;

	assign head_ext = {{11{heading_q[31]}}, heading_q};
	assign q_ext    = {2'd0, q_q};
	assign head_sum = rneg_q ? (head_ext - q_ext) : (head_ext + q_ext);

	always_comb begin
		if (head_sum[42:31] == {12{head_sum[42]}}) begin
			head_nx = head_sum[31:0];
		end else if (head_sum[42]) begin
			head_nx = 32'h8000_0000;
		end else begin
			head_nx = 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			kind_q      <= 1'b0;
			sum_q       <= 16'd0;
			bias_q      <= 16'd0;
			prev_q      <= '0;
			heading_q   <= '0;
			time_q      <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (item_fire) begin
				kind_q <= item.cmd;
				sum_q  <= sum_nx;
				cnt_q  <= group_done ? '0 : cnt_inc;
				if (group_done && !item.cmd) begin
					bias_q <= sum_nx;
					time_q <= 32'd0;
				end else begin
					time_q <= time_nx;
				end
			end
			if (ctrl.op == OP_HEAD) begin
				heading_q   <= signed'(head_nx);
				prev_q      <= rate_q;
				time_q      <= 32'd0;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
		end
		unique case (ctrl.op)
			OP_DIFF: begin
				mag_q  <= diff_mag;
				neg_q  <= diff[16];
				zero_q <= diff_mag < {1'b0, cfg.deadband_sum};
			end
			OP_RATE: rate_q <= signed'(rate_nx);
			OP_RSUM: begin
				secs_q <= prod_q;
				rneg_q <= rsum[24];
				rmag_q <= rsum[24] ? (25'd0 - rsum) : rsum;
			end
			OP_LOAD_A: a_q <= prod_q[56:0];
			OP_QUOT:   q_q <= q_sat;
			OP_HEAD:   result_q <= '{heading: signed'(head_nx), rate: rate_q};
			default: ;
		endcase
	end

	assign result       = result_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/gyro_heading_integrator.sv
// Top level of the gyro heading integrator: configuration registers, sequencer and datapath.
// A sample that does not close a measure group is taken at the idle step, and the next
// sample may follow in the next cycle. A sample that closes a measure group starts an
// eight-step microprogram on the shared 32x32 multiplier; no new sample is taken until it is
// back at idle, and its result is registered at the last step, held off by any output stall.
// Reset clears the group, bias, rate, heading and tick state and loads register defaults.
`default_nettype none

module gyro_heading_integrator #(
	parameter int AVG_COUNT = ghi_pkg::AVG_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ghi_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output ghi_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import ghi_pkg::*;

	// Configuration registers. The port always takes a beat; writes to an index
	// beyond the register list are dropped. Writes are only expected while idle.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband_sum <= DEADBAND_RESET;
			cfg_q.rate_gain    <= RATE_GAIN_RESET;
			cfg_q.tick_gain    <= TICK_GAIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEADBAND:  cfg_q.deadband_sum <= cfg_data[15:0];
				CFG_RATE_GAIN: cfg_q.rate_gain    <= cfg_data[15:0];
				CFG_TICK_GAIN: cfg_q.tick_gain    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The sequencer steps through the control store; the datapath executes
	// each control word and reports back whether a measure group has closed
	// and whether the output register is still occupied.
	dp_ctrl_t   ctrl;
	dp_status_t status;

	// Samples are taken only while the program sits at its idle step. The
	// output register decouples the result side, so samples keep flowing
	// while a finished result waits to be taken.
	assign item_stall = (ctrl.op != OP_IDLE);

	ghi_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	ghi_datapath #(
		.AVG_COUNT (AVG_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status)
	);

endmodule

`default_nettype wire

// File: tb/sv/gyro_heading_integrator_tb.sv
// Self-checking testbench for the gyro heading integrator with an in-bench heading predictor.
`default_nettype none

module gyro_heading_integrator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ghi_pkg::*;

	localparam int AVG     = AVG_COUNT_DEF;
	localparam int MAX_SUM = 4095 * AVG;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	gyro_heading_integrator #(.AVG_COUNT(AVG)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Register copies held by the predictor. They only change while the block is idle,
	// so the stimulus generator reads them too when it aims groups at the deadband edges.
	logic [15:0] db_reg = DEADBAND_RESET;
	logic [15:0] rgain_reg = RATE_GAIN_RESET;
	logic [31:0] tgain_reg = TICK_GAIN_RESET;

	// Predictor state: open group, stored bias, last rate, heading and the tick counter.
	logic [3:0] grp_cnt = '0;
	logic grp_cmd = 1'b0;
	logic [15:0] grp_sum = '0;
	logic [15:0] bias_est = '0;
	logic signed [23:0] last_rate = '0;
	logic signed [31:0] heading_est = '0;
	logic [31:0] tick_acc = '0;

	// Samples waiting to be sent, and heading/rate pairs waiting to come back.
	item_t sample_q[$];
	result_t heading_rate_q[$];

	int mismatches = 0;
	bit no_idle = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int planned_bias = 0;

	// Rate from the closed measure group: bias removed, deadband applied, then scaled by
	// rate_gain with the low 12 bits of the product dropped and the magnitude capped.
	function automatic logic signed [23:0] scale_rate();
		logic signed [17:0] diff;
		logic [16:0] mag;
		logic [47:0] scaled;
		diff = $signed({2'b00, grp_sum}) - $signed({2'b00, bias_est});
		mag = diff[17] ? 17'(-diff) : 17'(diff);
		if (mag < {1'b0, db_reg})
			return '0;
		scaled = (48'(mag) * 48'(rgain_reg)) >> 12;
		if (scaled > 48'd8388607)
			scaled = 48'd8388607;
		return diff[17] ? -24'(scaled) : 24'(scaled);
	endfunction

	// Trapezoid step: (old rate + new rate) / 2 times the elapsed seconds in Q32.32. The
	// magnitude is truncated toward zero and capped at 2^40 before the sign is restored.
	function automatic logic signed [41:0] heading_step(input logic signed [24:0] rsum);
		logic [24:0] mag;
		logic [63:0] secs;
		logic [95:0] prod;
		logic [62:0] q;
		mag = rsum[24] ? 25'(-rsum) : 25'(rsum);
		secs = 64'(tick_acc) * 64'(tgain_reg);
		prod = 96'(mag) * 96'(secs);
		q = prod[95:33];
		if (q > (63'd1 << 40))
			q = 63'd1 << 40;
		return rsum[24] ? -42'(q) : 42'(q);
	endfunction

	// Advances the predictor by one accepted sample and queues a heading/rate pair when a
	// measure group closes.
	function automatic void integrate_sample(input item_t s);
		logic [32:0] tsum;
		logic signed [23:0] new_rate;
		logic signed [41:0] delta;
		longint h;
		result_t r;
		tsum = {1'b0, tick_acc} + {17'b0, s.elapsed_ticks};
		tick_acc = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
		// A sample of the other kind throws away the partial group.
		if (grp_cnt == 4'd0 || s.cmd != grp_cmd) begin
			grp_cmd = s.cmd;
			grp_cnt = '0;
			grp_sum = '0;
		end
		grp_sum = grp_sum + {4'b0, s.sample};
		grp_cnt = grp_cnt + 4'd1;
		if (grp_cnt < AVG)
			return;
		grp_cnt = '0;
		if (!grp_cmd) begin
			// Calibration only replaces the bias and restarts the time base.
			bias_est = grp_sum;
			tick_acc = '0;
			return;
		end
		new_rate = scale_rate();
		delta = heading_step({last_rate[23], last_rate} + {new_rate[23], new_rate});
		h = longint'(heading_est) + longint'(delta);
		if (h > longint'(32'sh7FFF_FFFF))
			h = longint'(32'sh7FFF_FFFF);
		if (h < longint'(32'sh8000_0000))
			h = longint'(32'sh8000_0000);
		heading_est = 32'(h);
		last_rate = new_rate;
		tick_acc = '0;
		r.heading = heading_est;
		r.rate = new_rate;
		heading_rate_q.push_back(r);
	endfunction

	// Idle lengths: mostly none or a few cycles, now and then a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 16);
	endfunction

	// Sender. The prediction is made at the edge where the beat is taken; a new beat is
	// only put up once the previous one is gone, so a stalled payload never moves.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (item_valid && !item_stall)
				integrate_sample(item);
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					item_valid <= 1'b0;
					send_gap--;
				end else if (sample_q.size() != 0) begin
					item <= sample_q.pop_front();
					item_valid <= 1'b1;
					send_gap = no_idle ? 0 : draw_gap();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each result beat is checked field by field against the oldest pending
	// pair; stall runs are drawn independently of result_valid.
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (heading_rate_q.size() == 0) begin
					$display("%0t: result beat with nothing pending, expected none, %s %0d rate %0d",
						$time, "got heading", result.heading, result.rate);
					mismatches++;
				end else begin
					exp_r = heading_rate_q.pop_front();
					if (result.heading !== exp_r.heading) begin
						$display("%0t: heading mismatch, expected %0d, got %0d",
							$time, exp_r.heading, result.heading);
						mismatches++;
					end
					if (result.rate !== exp_r.rate) begin
						$display("%0t: rate mismatch, expected %0d, got %0d",
							$time, exp_r.rate, result.rate);
						mismatches++;
					end
				end
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				if (!no_idle && $urandom_range(2) == 0)
					stall_left = draw_gap();
			end
		end
	end

	// Register writes happen only with the block idle; the predictor copy follows the
	// write at the edge where it is taken.
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DEADBAND: db_reg = val[15:0];
			CFG_RATE_GAIN: rgain_reg = val[15:0];
			CFG_TICK_GAIN: tgain_reg = val;
			default: ;
		endcase
	endtask

	// Waits until every queued sample is sent and every pending result has come back,
	// then lets the block settle past its longest internal sequence.
	task automatic drain_all();
		do @(posedge clk);
		while (sample_q.size() != 0 || item_valid || heading_rate_q.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic push_sample(input logic cmd, input logic [11:0] smp, input logic [15:0] ticks);
		item_t s;
		s.cmd = cmd;
		s.sample = smp;
		s.elapsed_ticks = ticks;
		sample_q.push_back(s);
	endtask

	function automatic logic [15:0] pick_ticks();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(65535));
	endfunction

	// One full group whose samples add up to the target sum, spread at random over the
	// samples so that single samples still reach both ends of the code range.
	task automatic push_group(input logic cmd, input int target);
		int rem;
		int lo;
		int hi;
		int smp;
		if (target < 0)
			target = 0;
		if (target > MAX_SUM)
			target = MAX_SUM;
		rem = target;
		for (int i = 0; i < AVG; i++) begin
			lo = rem - 4095 * (AVG - 1 - i);
			if (lo < 0)
				lo = 0;
			hi = (rem > 4095) ? 4095 : rem;
			smp = $urandom_range(hi, lo);
			rem -= smp;
			push_sample(cmd, 12'(smp), pick_ticks());
		end
		if (!cmd)
			planned_bias = target;
	endtask

	// Measure targets cluster on both sides of the deadband edges around the bias.
	function automatic int measure_target();
		int d;
		d = int'(db_reg);
		case ($urandom_range(7))
			0: return planned_bias + d - 1;
			1: return planned_bias - d + 1;
			2: return planned_bias + d;
			3: return planned_bias - d;
			4: return planned_bias + $urandom_range(4000) - 2000;
			5: return 0;
			6: return MAX_SUM;
			default: return $urandom_range(MAX_SUM);
		endcase
	endfunction

	// Mostly whole groups with random content, the rest broken groups and stray samples.
	task automatic queue_random(input int count);
		int sent;
		int r;
		int k;
		logic c;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 70) begin
				if ($urandom_range(4) != 0)
					push_group(1'b1, measure_target());
				else if ($urandom_range(5) == 0)
					push_group(1'b0, ($urandom_range(1) == 0) ? 0 : MAX_SUM);
				else
					push_group(1'b0, $urandom_range(MAX_SUM));
				sent += AVG;
			end else if (r < 90) begin
				k = $urandom_range(AVG - 1, 1);
				c = 1'($urandom_range(1));
				for (int i = 0; i < k; i++)
					push_sample(c, 12'($urandom_range(4095)), pick_ticks());
				sent += k;
			end else begin
				push_sample(1'($urandom_range(1)), 12'($urandom_range(4095)), pick_ticks());
				sent += 1;
			end
		end
	endtask

	// One setting of the registers: a stretch with random idling, then one without.
	task automatic run_phase(input int count);
		no_idle = 1'b0;
		queue_random(count / 2);
		wait (sample_q.size() == 0);
		no_idle = 1'b1;
		queue_random(count - count / 2);
		drain_all();
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings. A partial measure group is cut off by a
		// calibration group, which must replace it and then set the bias without a result.
		push_sample(1'b1, 12'hFFF, 16'hFFFF);
		push_sample(1'b1, 12'h000, 16'hFFFF);
		for (int i = 0; i < AVG; i++)
			push_sample(1'b0, (i % 2 == 0) ? 12'hFFF : 12'h000, 16'h0000);
		planned_bias = 4095 * ((AVG + 1) / 2);
		// Full-scale measure group, then one at the bias exactly (rate forced to zero).
		for (int i = 0; i < AVG; i++)
			push_sample(1'b1, 12'hFFF, 16'hFFFF);
		push_group(1'b1, planned_bias);
		drain_all();

		// Default settings, with a pause in the middle where the sender holds back until
		// every pending result has come home.
		queue_random(150);
		drain_all();
		run_phase(250);

		// Smallest deadband, largest gains: headings hit both saturation rails.
		write_reg(CFG_DEADBAND, 32'h0000_0000);
		write_reg(CFG_RATE_GAIN, 32'h0000_FFFF);
		write_reg(CFG_TICK_GAIN, 32'hFFFF_FFFF);
		run_phase(375);

		// Widest deadband, zero gains: rates and heading steps stay at zero.
		write_reg(CFG_DEADBAND, 32'h0000_FFFF);
		write_reg(CFG_RATE_GAIN, 32'h0000_0000);
		write_reg(CFG_TICK_GAIN, 32'h0000_0000);
		run_phase(375);

		// Moderate random settings where the deadband edges matter.
		write_reg(CFG_DEADBAND, 32'($urandom_range(2000)));
		write_reg(CFG_RATE_GAIN, 32'($urandom_range(65535)));
		write_reg(CFG_TICK_GAIN, 32'($urandom_range(32'h0010_0000)));
		run_phase(375);

		// Fully random settings.
		write_reg(CFG_DEADBAND, 32'($urandom_range(65535)));
		write_reg(CFG_RATE_GAIN, 32'($urandom_range(65535)));
		write_reg(CFG_TICK_GAIN, $urandom());
		run_phase(375);

		repeat (20) @(posedge clk);
		if (mismatches == 0 && heading_rate_q.size() == 0)
			$display("gyro_heading_integrator verification clean");
		else
			$display("gyro_heading_integrator verification failed");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#15_000_000;
		$display("gyro_heading_integrator verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hdl/ghi_pkg.sv
hdl/ghi_sequencer.sv
hdl/ghi_datapath.sv
hdl/gyro_heading_integrator.sv
tb/sv/gyro_heading_integrator_tb.sv
